// ===== rtl/core/nrid_pkg.sv =====
// Shared types, constants and helpers of the nibble run-length image decoder.
// Used by nrid_ctrl, nrid_datapath and the top level; depends on nothing.
package nrid_pkg;

  // Sizes
  localparam int PIXEL_COUNT_BITS     = 20;
  localparam int FILL_PIXELS_PER_ITEM = 64;
  localparam int FILL_CNT_W           = $clog2(FILL_PIXELS_PER_ITEM);
  localparam int WORD_W               = 32;
  localparam int NIB_W                = 4;
  localparam int NIB_PER_WORD         = WORD_W / NIB_W;
  localparam int NIB_CNT_W            = $clog2(NIB_PER_WORD) + 1;
  localparam int UNREAD_W             = 3;
  localparam int UNREAD_LIMIT         = 4;
  localparam int MASK_W               = 16;
  localparam int CFG_IDX_W            = 2;
  localparam int CFG_DATA_W           = (PIXEL_COUNT_BITS > MASK_W) ? PIXEL_COUNT_BITS : MASK_W;

  typedef logic [PIXEL_COUNT_BITS-1:0] pix_cnt_t;
  typedef logic [NIB_W-1:0]            nib_t;

  // Input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_TRUNC = 2'd1;
  localparam logic [1:0] STAT_LONG  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MASK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES  = 2'd2;

  // Datapath operations issued by the controller
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t DP_NONE      = 4'd0;
  localparam dp_op_t DP_START     = 4'd1;
  localparam dp_op_t DP_UNREAD    = 4'd2;
  localparam dp_op_t DP_LOAD      = 4'd3;
  localparam dp_op_t DP_NIB       = 4'd4;
  localparam dp_op_t DP_REP       = 4'd5;
  localparam dp_op_t DP_FILL_INIT = 4'd6;
  localparam dp_op_t DP_FILL      = 4'd7;
  localparam dp_op_t DP_STATUS    = 4'd8;
  localparam dp_op_t DP_FLUSH     = 4'd9;

  typedef struct packed {
    dp_op_t op;
  } nrid_cmd_t;

  typedef struct packed {
    logic adv;         // a result may be produced this cycle
    logic left_zero;   // no image pixels remain
    logic awaiting;    // next nibble is a repeat count
    logic cnt_nz;      // clamped repeat count of current nibble is nonzero
    logic last_nib;    // current nibble is the last of the word
    logic word_empty;  // all nibbles of the word consumed
    logic rep_one;     // one repeat pixel remains
    logic fill_end;    // this fill pixel ends the fill chunk
  } nrid_stat_t;

  typedef struct packed {
    logic [7:0] pixel_pair;
    logic       byte_valid;
    logic       image_done;
    logic [1:0] status;
  } nrid_res_t;

  // Reverse byte order of a data word
  function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] w);
    byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/core/nrid_ctrl.sv =====
// Controller state machine of the nibble run-length image decoder.
// Sequences nibble, repeat and fill steps; depends on nrid_pkg.
module nrid_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_opcode,
  input  nrid_pkg::nrid_stat_t stat,
  output nrid_pkg::nrid_cmd_t  cmd
);
  import nrid_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NIB  = 3'd1;
  localparam logic [2:0] S_REP  = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_opcode)
            OP_START: cmd.op = DP_START;
            OP_DATA: begin
              if (stat.left_zero && !stat.awaiting) begin
                cmd.op = DP_UNREAD;
              end else begin
                cmd.op    = DP_LOAD;
                state_nxt = S_NIB;
              end
            end
            OP_END: begin
              if (stat.left_zero) begin
                cmd.op    = DP_STATUS;
                state_nxt = S_DONE;
              end else begin
                cmd.op    = DP_FILL_INIT;
                state_nxt = S_FILL;
              end
            end
            default: cmd.op = DP_NONE;
          endcase
        end
      end
      S_NIB: begin
        if (stat.left_zero && !stat.awaiting) begin
          state_nxt = S_DONE;
        end else if (stat.adv) begin
          cmd.op = DP_NIB;
          if (stat.awaiting && stat.cnt_nz) begin
            state_nxt = S_REP;
          end else if (stat.last_nib) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_REP: begin
        if (stat.adv) begin
          cmd.op = DP_REP;
          if (stat.rep_one) begin
            state_nxt = stat.word_empty ? S_DONE : S_NIB;
          end
        end
      end
      S_FILL: begin
        if (stat.adv) begin
          cmd.op = DP_FILL;
          if (stat.fill_end) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (stat.adv) begin
          cmd.op    = DP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/nrid_datapath.sv =====
// Datapath of the nibble run-length image decoder: config registers, decode
// state, pixel packing, held result and output register; depends on nrid_pkg.
module nrid_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nrid_pkg::nrid_cmd_t               cmd,
  output nrid_pkg::nrid_stat_t              stat,
  input  logic [nrid_pkg::WORD_W-1:0]       in_word,
  input  logic                              cfg_valid,
  input  logic [nrid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nrid_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  output logic [3:0]                        out_tuser
);
  import nrid_pkg::*;

  // Configuration
  logic [MASK_W-1:0] rle_mask_r;
  pix_cnt_t          pixel_count_r;
  logic              swap_bytes_r;

  // Decode state
  pix_cnt_t              left_r, left_nxt;
  nib_t                  pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;
  nib_t                  colour_r, colour_nxt;
  logic                  await_r, await_nxt;
  logic [UNREAD_W-1:0]   unread_r, unread_nxt;
  logic [1:0]            err_r, err_nxt;
  logic                  fin_r, fin_nxt;
  logic [WORD_W-1:0]     word_r, word_nxt;
  logic [NIB_CNT_W-1:0]  nib_cnt_r, nib_cnt_nxt;
  nib_t                  rep_r, rep_nxt;
  logic [FILL_CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;

  // Held result and output register
  logic      hold_v_r, hold_v_nxt;
  nrid_res_t hold_r, hold_nxt;
  logic      out_v_r, out_v_nxt;
  nrid_res_t out_r, out_nxt;
  logic      out_last_r, out_last_nxt;

  // Step helpers
  nib_t      nib;
  logic      nib_gt;
  nib_t      nib_clamp;
  logic      px_en;
  nib_t      px_col;
  pix_cnt_t  left_dec;
  logic      emit;
  nrid_res_t emit_res;
  logic      flush;

  assign nib       = word_r[NIB_W-1:0];
  assign nib_gt    = {{(PIXEL_COUNT_BITS-NIB_W){1'b0}}, nib} > left_r;
  assign nib_clamp = nib_gt ? left_r[NIB_W-1:0] : nib;
  assign left_dec  = left_r - PIXEL_COUNT_BITS'(1);

  // Status toward the controller
  always_comb begin
    stat.adv        = !(hold_v_r && out_v_r && !out_tready);
    stat.left_zero  = (left_r == '0);
    stat.awaiting   = await_r;
    stat.cnt_nz     = (nib_clamp != '0);
    stat.last_nib   = (nib_cnt_r == NIB_CNT_W'(NIB_PER_WORD - 1));
    stat.word_empty = (nib_cnt_r == NIB_CNT_W'(NIB_PER_WORD));
    stat.rep_one    = (rep_r == NIB_W'(1));
    stat.fill_end   = (left_r == PIXEL_COUNT_BITS'(1)) ||
                      (fill_cnt_r == FILL_CNT_W'(FILL_PIXELS_PER_ITEM - 1));
  end

  // Decode step
  always_comb begin
    left_nxt     = left_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    colour_nxt   = colour_r;
    await_nxt    = await_r;
    unread_nxt   = unread_r;
    err_nxt      = err_r;
    fin_nxt      = fin_r;
    word_nxt     = word_r;
    nib_cnt_nxt  = nib_cnt_r;
    rep_nxt      = rep_r;
    fill_cnt_nxt = fill_cnt_r;
    px_en        = 1'b0;
    px_col       = colour_r;
    emit         = 1'b0;
    emit_res     = '0;
    flush        = 1'b0;

    case (cmd.op)
      DP_START: begin
        left_nxt   = pixel_count_r;
        pend_nxt   = '0;
        pend_v_nxt = 1'b0;
        colour_nxt = '0;
        await_nxt  = 1'b0;
        unread_nxt = '0;
        err_nxt    = STAT_OK;
        fin_nxt    = (pixel_count_r == '0);
      end
      DP_UNREAD: begin
        if (unread_r != {UNREAD_W{1'b1}}) begin
          unread_nxt = unread_r + UNREAD_W'(1);
        end
      end
      DP_LOAD: begin
        word_nxt    = swap_bytes_r ? byte_swap(in_word) : in_word;
        nib_cnt_nxt = '0;
      end
      DP_NIB: begin
        word_nxt    = {{NIB_W{1'b0}}, word_r[WORD_W-1:NIB_W]};
        nib_cnt_nxt = nib_cnt_r + NIB_CNT_W'(1);
        if (await_r) begin
          await_nxt = 1'b0;
          if (nib_gt) begin
            err_nxt = STAT_LONG;
          end
          rep_nxt = nib_clamp;
        end else begin
          colour_nxt = nib;
          px_en      = 1'b1;
          px_col     = nib;
          await_nxt  = rle_mask_r[nib];
        end
      end
      DP_REP: begin
        rep_nxt = rep_r - NIB_W'(1);
        px_en   = 1'b1;
      end
      DP_FILL_INIT: begin
        err_nxt      = STAT_TRUNC;
        await_nxt    = 1'b0;
        fill_cnt_nxt = '0;
      end
      DP_FILL: begin
        fill_cnt_nxt = fill_cnt_r + FILL_CNT_W'(1);
        px_en        = 1'b1;
      end
      DP_STATUS: begin
        if (await_r) begin
          err_nxt   = STAT_TRUNC;
          await_nxt = 1'b0;
        end else if (fin_r && unread_r > UNREAD_W'(UNREAD_LIMIT)) begin
          err_nxt = STAT_LONG;
        end
        emit                = 1'b1;
        emit_res.pixel_pair = '0;
        emit_res.byte_valid = 1'b0;
        emit_res.image_done = (left_r == '0) && fin_r;
        emit_res.status     = err_nxt;
      end
      DP_FLUSH: flush = 1'b1;
      default: ;
    endcase

    // Emit one pixel; pair it up or pad the final odd one
    if (px_en) begin
      left_nxt            = left_dec;
      emit_res.byte_valid = 1'b1;
      emit_res.image_done = (left_dec == '0);
      emit_res.status     = err_nxt;
      if (left_dec == '0) begin
        fin_nxt = 1'b1;
      end
      if (pend_v_r) begin
        emit                = 1'b1;
        emit_res.pixel_pair = {pend_r, px_col};
        pend_v_nxt          = 1'b0;
      end else if (left_dec == '0) begin
        emit                = 1'b1;
        emit_res.pixel_pair = {px_col, {NIB_W{1'b0}}};
        pend_v_nxt          = 1'b0;
      end else begin
        pend_nxt   = px_col;
        pend_v_nxt = 1'b1;
      end
    end
  end

  // Move results through the held slot into the output register
  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = emit_res;
    end else if (flush && hold_v_r) begin
      out_v_nxt    = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mask_r    <= '0;
      pixel_count_r <= '0;
      swap_bytes_r  <= 1'b0;
      left_r        <= '0;
      pend_r        <= '0;
      pend_v_r      <= 1'b0;
      colour_r      <= '0;
      await_r       <= 1'b0;
      unread_r      <= '0;
      err_r         <= STAT_OK;
      fin_r         <= 1'b0;
      hold_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RLE_MASK:    rle_mask_r    <= cfg_data[MASK_W-1:0];
          CFG_PIXEL_COUNT: pixel_count_r <= cfg_data[PIXEL_COUNT_BITS-1:0];
          CFG_SWAP_BYTES:  swap_bytes_r  <= cfg_data[0];
          default: ;
        endcase
      end
      left_r   <= left_nxt;
      pend_r   <= pend_nxt;
      pend_v_r <= pend_v_nxt;
      colour_r <= colour_nxt;
      await_r  <= await_nxt;
      unread_r <= unread_nxt;
      err_r    <= err_nxt;
      fin_r    <= fin_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    nib_cnt_r  <= nib_cnt_nxt;
    rep_r      <= rep_nxt;
    fill_cnt_r <= fill_cnt_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.pixel_pair;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_r.status, out_r.image_done, out_r.byte_valid};

  // A waiting half pixel always has an image pixel left to pair with
  a_pend_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (left_r != '0))
    else $error("pending pixel with no pixels left");

  // The output register is only ever loaded from the held slot
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(hold_v_r))
    else $error("output loaded without a held result");

  // A repeat step never runs on an exhausted count
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_REP) |-> (rep_r != '0) && (left_r != '0))
    else $error("repeat step with zero count");

  // Nothing produces a result while a held result is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && out_v_r && !out_tready) |-> !emit && !flush)
    else $error("result produced while output stalled");

endmodule

// ===== rtl/core/nibble_rle_image_decoder.sv =====
// Sequence: a start or an ignored beat is taken in the idle state; a data word is
// loaded, then stepped once per nibble and once per repeated pixel, then its last
// result is released from the held slot into the output register.
// Throughput: no new beat is taken until the last one's steps are done, set by the
// single nibble/pixel step unit, which handles one step a cycle unless the output stalls.
// Reset: synchronous active-low rst_n clears config and decode state, not payload registers.
module nibble_rle_image_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [nrid_pkg::WORD_W-1:0]           in_tdata,   // data_word
  input  logic [1:0]                            in_tuser,   // opcode
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // pixel_pair
  output logic                                  out_tlast,  // last_of_run
  output logic [3:0]                            out_tuser,  // byte_valid, image_done, status[1:0]
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nrid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nrid_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nrid_pkg::*;

  nrid_cmd_t  cmd;
  nrid_stat_t stat;

  // Registers take writes at any time
  assign cfg_ready = 1'b1;

  nrid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  nrid_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_word    (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sim/nrid_checker.sv =====
// Scoreboard of the nibble run-length image decoder: watches the config,
// input and result channels, predicts results and compares them field by field.
// Depends on nrid_pkg for widths, opcodes, status codes and register indexes.
module nrid_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic [nrid_pkg::WORD_W-1:0]           in_tdata,   // data_word
  input  logic [1:0]                            in_tuser,   // opcode
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic [7:0]                            out_tdata,  // pixel_pair
  input  logic                                  out_tlast,  // last_of_run
  input  logic [3:0]                            out_tuser,  // byte_valid, image_done, status[1:0]
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [nrid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nrid_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    mismatch_count,
  output int                                    pending
);
  import nrid_pkg::*;

  localparam int MAX_BEAT_RESULTS = 33;

  typedef struct packed {
    logic [7:0] pair;
    logic       data_flag;
    logic       last;
    logic       done;
    logic [1:0] stat;
  } pix_result_t;

  // Register copies
  logic [MASK_W-1:0]   mask_q = '0;
  pix_cnt_t            count_q = '0;
  logic                swap_q = 1'b0;

  // Decode state
  pix_cnt_t            px_left = '0;
  nib_t                held_pix = '0;
  logic                held_vld = 1'b0;
  nib_t                run_colour = '0;
  logic                want_count = 1'b0;
  logic [UNREAD_W-1:0] spare_words = '0;
  logic [1:0]          err_code = STAT_OK;
  logic                img_done = 1'b0;

  pix_result_t         expected_bytes[$];
  int                  beat_results;

  initial begin
    mismatch_count = 0;
    pending = 0;
  end

  task automatic emit_result(input logic [7:0] pair, input logic is_data);
    pix_result_t r;
    if (beat_results < MAX_BEAT_RESULTS) begin
      r.pair = pair;
      r.data_flag = is_data;
      r.last = 1'b0;
      r.done = (px_left == 0) && img_done;
      r.stat = err_code;
      expected_bytes.push_back(r);
      beat_results++;
    end
  endtask

  // Pair pixels two per byte; pad an odd final pixel with a zero nibble
  task automatic emit_pixel(input nib_t c);
    if (px_left != 0) begin
      px_left--;
      if (px_left == 0) img_done = 1'b1;
      if (held_vld) begin
        emit_result({held_pix, c}, 1'b1);
        held_vld = 1'b0;
      end else begin
        held_pix = c;
        held_vld = 1'b1;
      end
      if (px_left == 0 && held_vld) begin
        emit_result({held_pix, 4'h0}, 1'b1);
        held_vld = 1'b0;
      end
    end
  endtask

  // Work out every result caused by one input beat
  task automatic decode_beat(input logic [1:0] op, input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] w;
    nib_t              nib;
    pix_cnt_t          reps;
    pix_result_t       tail;
    int                i;
    int                n;
    beat_results = 0;
    case (op)
      OP_START: begin
        px_left = count_q;
        held_pix = '0;
        held_vld = 1'b0;
        run_colour = '0;
        want_count = 1'b0;
        spare_words = '0;
        err_code = STAT_OK;
        img_done = (count_q == 0);
      end
      OP_DATA: begin
        if (px_left == 0 && !want_count) begin
          if (spare_words != '1) spare_words++;
        end else begin
          w = swap_q ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
          for (i = 0; i < NIB_PER_WORD; i++) begin
            nib = w[NIB_W*i +: NIB_W];
            // drop the rest of the word once the image is complete
            if (px_left == 0 && !want_count) break;
            if (want_count) begin
              want_count = 1'b0;
              reps = pix_cnt_t'(nib);
              if (reps > px_left) begin
                err_code = STAT_LONG;
                reps = px_left;
              end
              repeat (reps) emit_pixel(run_colour);
            end else begin
              run_colour = nib;
              emit_pixel(nib);
              if (mask_q[nib]) want_count = 1'b1;
            end
          end
        end
      end
      OP_END: begin
        if (px_left > 0) begin
          // early end: fill one chunk with the current colour
          err_code = STAT_TRUNC;
          want_count = 1'b0;
          for (n = 0; n < FILL_PIXELS_PER_ITEM && px_left > 0; n++) emit_pixel(run_colour);
        end else if (want_count) begin
          err_code = STAT_TRUNC;
          want_count = 1'b0;
          emit_result(8'h00, 1'b0);
        end else begin
          if (img_done && spare_words > UNREAD_LIMIT) err_code = STAT_LONG;
          emit_result(8'h00, 1'b0);
        end
      end
      default: ;
    endcase
    if (beat_results > 0) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pix_result_t exp_r;
    if (!rst_n) begin
      mask_q = '0;
      count_q = '0;
      swap_q = 1'b0;
      px_left = '0;
      held_pix = '0;
      held_vld = 1'b0;
      run_colour = '0;
      want_count = 1'b0;
      spare_words = '0;
      err_code = STAT_OK;
      img_done = 1'b0;
      expected_bytes.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RLE_MASK:    mask_q = cfg_data[MASK_W-1:0];
          CFG_PIXEL_COUNT: count_q = cfg_data[PIXEL_COUNT_BITS-1:0];
          CFG_SWAP_BYTES:  swap_q = cfg_data[0];
          default: ;
        endcase
      end
      // Predict on every accepted input beat
      if (in_tvalid && in_tready) decode_beat(in_tuser, in_tdata);
      // Compare every accepted result beat with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("result beat with nothing expected: pixel_pair %0d tuser %0d",
                 out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          exp_r = expected_bytes.pop_front();
          check_field("pixel_pair", exp_r.pair, out_tdata);
          check_field("byte_valid", exp_r.data_flag, out_tuser[0]);
          check_field("last_of_run", exp_r.last, out_tlast);
          check_field("image_done", exp_r.done, out_tuser[1]);
          check_field("status", exp_r.stat, out_tuser[3:2]);
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top of the nibble run-length image decoder: clock, reset, stimulus,
// ready/idle patterns, watchdog and verdict. Depends on nrid_pkg, the decoder
// and nrid_checker.
module tb_top;
  import nrid_pkg::*;

  localparam logic [1:0] OP_IGNORED     = 2'd3;
  localparam int         SETTLE_CYCLES  = 100;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         RANDOM_ITEMS   = 450;
  localparam int         NUM_PHASES     = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata;   // data_word
  logic [1:0]            in_tuser;   // opcode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // pixel_pair
  logic                  out_tlast;  // last_of_run
  logic [3:0]            out_tuser;  // byte_valid, image_done, status[1:0]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  nibble_rle_image_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  nrid_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one input beat after random idle cycles; return at the next falling edge
  task automatic push_beat(input logic [1:0] op, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (op != OP_IGNORED) beats_sent++;
  endtask

  // Drain all expected results, then let the block settle
  task automatic wait_idle();
    in_tvalid = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write all three registers once the block is idle; junk in unused upper bits
  task automatic set_image_regs(input logic [MASK_W-1:0] mask, input pix_cnt_t count,
                                input logic swap);
    wait_idle();
    write_reg(CFG_RLE_MASK, {4'($urandom_range(15)), mask});
    write_reg(CFG_PIXEL_COUNT, count);
    write_reg(CFG_SWAP_BYTES, {19'($urandom), swap});
  endtask

  // One image: registers, start, compressed words, stray words, end beats
  task automatic run_image(input bit pressure);
    logic [MASK_W-1:0] mask;
    pix_cnt_t          count;
    logic              swap;
    int                nwords;
    int                ntrail;
    int                nend;
    int                i;
    case ($urandom_range(3))
      0:       mask = '0;
      1:       mask = '1;
      default: mask = MASK_W'($urandom);
    endcase
    case ($urandom_range(19))
      0:       count = '0;
      1:       count = pix_cnt_t'($urandom_range(300, 900));
      default: count = pix_cnt_t'($urandom_range(1, 120));
    endcase
    swap = 1'($urandom_range(1));
    nwords = count / 8 + $urandom_range(0, 2);
    if ($urandom_range(3) == 0) nwords = $urandom_range(0, nwords);
    if (nwords > 16) nwords = 16;
    if (pressure) begin
      mask = '1;
      count = pix_cnt_t'(800);
      nwords = 14;
    end
    set_image_regs(mask, count, swap);
    // occasional noise ahead of the start
    if ($urandom_range(7) == 0) push_beat(OP_IGNORED, $urandom);
    if ($urandom_range(11) == 0) push_beat(OP_DATA, $urandom);
    push_beat(OP_START, $urandom);
    if (pressure) hold_reqs++;
    for (i = 0; i < nwords; i++) begin
      if ($urandom_range(29) == 0) push_beat(OP_IGNORED, $urandom);
      push_beat(OP_DATA, $urandom);
    end
    ntrail = ($urandom_range(3) == 0) ? $urandom_range(1, 9) : 0;
    for (i = 0; i < ntrail; i++) push_beat(OP_DATA, $urandom);
    nend = $urandom_range(1, 3);
    if ($urandom_range(1)) nend += count / FILL_PIXELS_PER_ITEM;
    for (i = 0; i < nend; i++) push_beat(OP_END, $urandom);
  endtask

  initial begin
    int phase;
    int target;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_START;
    cfg_valid = 1'b0;
    cfg_index = CFG_RLE_MASK;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Ignored opcode and an end of data straight after reset
    push_beat(OP_IGNORED, 32'hFFFF_FFFF);
    push_beat(OP_END, 32'h0000_0000);
    // Overlong repeat clamped at the image end, rest of the word dropped
    set_image_regs(16'hFFFF, 20'd20, 1'b1);
    push_beat(OP_START, 32'h0);
    push_beat(OP_DATA, 32'hFFFF_FFFF);
    // Words after completion, then end of data flags too long
    repeat (5) push_beat(OP_DATA, $urandom);
    push_beat(OP_END, 32'h0);
    // Empty image is done at once
    set_image_regs(16'h0000, 20'd0, 1'b0);
    push_beat(OP_START, 32'h0);
    push_beat(OP_END, 32'h0);
    // Largest pixel count, abandoned by the next start
    set_image_regs(16'h5A5A, '1, 1'b1);
    push_beat(OP_START, 32'h0);
    push_beat(OP_DATA, $urandom);
    // Early end of data: fill in chunks, then status report
    set_image_regs(16'h0000, 20'd100, 1'b0);
    push_beat(OP_START, 32'h0);
    push_beat(OP_DATA, 32'h7654_3210);
    repeat (3) push_beat(OP_END, 32'h0);
    // Nonzero count nibble after the last pixel
    set_image_regs(16'h0008, 20'd3, 1'b0);
    push_beat(OP_START, 32'h0);
    push_beat(OP_DATA, 32'h0000_5321);
    // End of data while a count nibble is still awaited
    set_image_regs(16'h0080, 20'd8, 1'b0);
    push_beat(OP_START, 32'h0);
    push_beat(OP_DATA, 32'h7111_1111);
    push_beat(OP_END, 32'h0);

    // Random images under each idle pattern
    target = beats_sent;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      target += RANDOM_ITEMS / NUM_PHASES;
      if (phase == 0) run_image(1'b1);
      while (beats_sent < target) run_image(1'b0);
    end

    wait_idle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nrid_pkg.sv
rtl/core/nrid_ctrl.sv
rtl/core/nrid_datapath.sv
rtl/core/nibble_rle_image_decoder.sv
sim/nrid_checker.sv
sim/tb_top.sv
